// ----- hdl/ghcc_pkg.sv -----
// Shared types and constants for the gear-hash content chunker.
`timescale 1ns / 1ps
`default_nettype none

package ghcc_pkg;

  // Width of the size registers and of the reported chunk length
  localparam int unsigned LenCfgW = 23;
  // Width of the cut masks; only the low hash bits this wide ever reach a mask
  localparam int unsigned MaskW   = 32;
  localparam int unsigned GearW   = 64;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [LenCfgW-1:0] DefMinSize   = LenCfgW'(16384);
  localparam logic [LenCfgW-1:0] DefAvgSize   = LenCfgW'(65536);
  localparam logic [LenCfgW-1:0] DefMaxSize   = LenCfgW'(262144);
  localparam logic [MaskW-1:0]   DefEarlyMask = MaskW'(131071);
  localparam logic [MaskW-1:0]   DefLateMask  = MaskW'(32767);

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinSize   = 3'd0,
    CfgAvgSize   = 3'd1,
    CfgMaxSize   = 3'd2,
    CfgEarlyMask = 3'd3,
    CfgLateMask  = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ModeData      = 1'b0,
    ModeGearWrite = 1'b1
  } mode_e;

  typedef struct packed {
    logic              mode;
    logic [ByteW-1:0]  data_byte;
    logic              end_of_stream;
    logic [ByteW-1:0]  gear_index;
    logic [GearW-1:0]  gear_value;
  } in_item_t;

  typedef struct packed {
    logic               chunk_end;
    logic [LenCfgW-1:0] chunk_length;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/ghcc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ghcc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while re_i is low
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/gear_hash_content_chunker.sv -----
// Gear-hash content-defined chunker: top level.
// Takes one stream byte per cycle while the output side keeps up and
// returns, per data byte, whether it closes a chunk and the chunk length so
// far; gear-table writes give no result. A data byte first reads the gear
// table RAM (registered read port); then the shift-add hash update, mask
// test and length compare load the result register. The hash/offset
// feedback closes within that hash step, so a byte can be taken every cycle
// and throughput is one item per cycle when the output side keeps up.
// Configuration writes apply to bytes accepted after the write, and also to
// a byte already accepted but not yet hashed. The gear table is not cleared
// by reset; load every entry before streaming data.
`timescale 1ns / 1ps
`default_nettype none

module gear_hash_content_chunker #(
  parameter int unsigned MaxChunk = 4194304
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire ghcc_pkg::in_item_t                  in_item_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output ghcc_pkg::out_item_t                      out_item_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [ghcc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [ghcc_pkg::MaskW-1:0]          cfg_wdata_i
);

  localparam int unsigned OffW = $clog2(MaxChunk);
  localparam int unsigned LenW = $clog2(MaxChunk + 1);
  localparam int unsigned CmpW = (LenW > ghcc_pkg::LenCfgW) ? LenW : ghcc_pkg::LenCfgW;
  localparam int unsigned MaxRst =
      (262144 > MaxChunk) ? MaxChunk : 262144;

  // ---------------- configuration ----------------
  logic [ghcc_pkg::LenCfgW-1:0] min_size_q, avg_size_q;
  logic [LenW-1:0]              eff_max_q;
  logic [ghcc_pkg::MaskW-1:0]   early_mask_q, late_mask_q;
  logic [CmpW-1:0]              wr_size;
  logic [LenW-1:0]              eff_max_d;

  assign wr_size = CmpW'(cfg_wdata_i[ghcc_pkg::LenCfgW-1:0]);

  // forced cut length: zero acts as one, large values saturate
  always_comb begin
    if (wr_size == '0) begin
      eff_max_d = LenW'(1);
    end else if (wr_size > CmpW'(MaxChunk)) begin
      eff_max_d = LenW'(MaxChunk);
    end else begin
      eff_max_d = wr_size[LenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q   <= ghcc_pkg::DefMinSize;
      avg_size_q   <= ghcc_pkg::DefAvgSize;
      eff_max_q    <= LenW'(MaxRst);
      early_mask_q <= ghcc_pkg::DefEarlyMask;
      late_mask_q  <= ghcc_pkg::DefLateMask;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ghcc_pkg::CfgMinSize:   min_size_q   <= cfg_wdata_i[ghcc_pkg::LenCfgW-1:0];
        ghcc_pkg::CfgAvgSize:   avg_size_q   <= cfg_wdata_i[ghcc_pkg::LenCfgW-1:0];
        ghcc_pkg::CfgMaxSize:   eff_max_q    <= eff_max_d;
        ghcc_pkg::CfgEarlyMask: early_mask_q <= cfg_wdata_i;
        ghcc_pkg::CfgLateMask:  late_mask_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- handshake and stage control ----------------
  logic s1_valid_q, s1_valid_d;
  logic s1_eos_q;
  logic out_valid_q, out_valid_d;
  logic advance, in_xfer, data_xfer, gear_xfer;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign data_xfer  = in_xfer && (in_item_i.mode == ghcc_pkg::ModeData);
  assign gear_xfer  = in_xfer && (in_item_i.mode == ghcc_pkg::ModeGearWrite);

  // Only the low mask-width bits of each gear word ever influence a cut.
  logic [ghcc_pkg::MaskW-1:0] gear_rd;

  ghcc_ram #(
    .Width(ghcc_pkg::MaskW),
    .Depth(256)
  ) u_gear_ram (
    .clk_i  (clk_i),
    .we_i   (gear_xfer),
    .waddr_i(in_item_i.gear_index),
    .wdata_i(in_item_i.gear_value[ghcc_pkg::MaskW-1:0]),
    .re_i   (data_xfer),
    .raddr_i(in_item_i.data_byte),
    .rdata_o(gear_rd)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (data_xfer) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = advance ? s1_valid_q : out_valid_q;
  end

  // ---------------- hash and cut decision ----------------
  logic [ghcc_pkg::MaskW-1:0] hash_q, hash_d, hash_sum, cut_mask;
  logic [OffW-1:0]            offset_q, offset_d;
  logic [LenW-1:0]            len;
  logic [CmpW-1:0]            off_ext, len_ext;
  logic                       hashing, cut;
  logic                       step;

  assign step     = advance && s1_valid_q;
  assign off_ext  = CmpW'(offset_q);
  assign len      = LenW'(offset_q) + LenW'(1);
  assign len_ext  = CmpW'(len);
  assign hashing  = off_ext >= CmpW'(min_size_q);
  assign cut_mask = (off_ext < CmpW'(avg_size_q)) ? early_mask_q : late_mask_q;
  assign hash_sum = {hash_q[ghcc_pkg::MaskW-2:0], 1'b0} + gear_rd;

  always_comb begin
    cut = s1_eos_q || (len >= eff_max_q);
    if (hashing && ((hash_sum & cut_mask) == '0)) begin
      cut = 1'b1;
    end
    if (cut) begin
      hash_d   = '0;
      offset_d = '0;
    end else begin
      hash_d   = hashing ? hash_sum : hash_q;
      offset_d = len[OffW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hash_q      <= '0;
      offset_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (step) begin
        hash_q   <= hash_d;
        offset_q <= offset_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (data_xfer) begin
      s1_eos_q <= in_item_i.end_of_stream;
    end
    if (step) begin
      out_item_o.chunk_end    <= cut;
      out_item_o.chunk_length <= len_ext[ghcc_pkg::LenCfgW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- hdl/ghcc_checker.sv -----
// Port-level checks for the gear-hash content chunker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ghcc_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire ghcc_pkg::in_item_t  in_item_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i
);

  // a result waiting for transfer is not withdrawn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // input is never held off while the output side can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled with free output");

  // a fresh result stems from a data-byte transfer by way of the gear-read register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_o) |->
        $past(in_valid_i && in_ready_o && (in_item_i.mode == ghcc_pkg::ModeData), 2))
    else $error("result without matching data byte");

  // a gear-table write never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_o && (in_item_i.mode == ghcc_pkg::ModeGearWrite)
        && !out_valid_o |=> ##1 !$rose(out_valid_o))
    else $error("result from a gear-table write");

endmodule

bind gear_hash_content_chunker ghcc_checker u_ghcc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i)
);

`default_nettype wire

// ----- test/gear_hash_content_chunker_tb.sv -----
// Self-checking testbench for the gear-hash content chunker.
`timescale 1ns / 1ps

module gear_hash_content_chunker_tb;

  localparam int unsigned MaxChunkLen  = 4194304;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned RandPhases   = 8;
  localparam int unsigned PhaseBytes   = 125;
  localparam logic [ghcc_pkg::LenCfgW-1:0] SizeAllOnes = '1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  ghcc_pkg::in_item_t in_item_i;
  logic out_valid_o;
  logic out_ready_i;
  ghcc_pkg::out_item_t out_item_o;
  logic cfg_we_i;
  logic [ghcc_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [ghcc_pkg::MaskW-1:0] cfg_wdata_i;

  always #5 clk_i = ~clk_i;

  gear_hash_content_chunker #(.MaxChunk(MaxChunkLen)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Shadow of the chunker state and registers
  logic [ghcc_pkg::GearW-1:0]   gear_shadow [256];
  logic [ghcc_pkg::GearW-1:0]   roll_hash = '0;
  int unsigned                  chunk_off = 0;
  logic [ghcc_pkg::LenCfgW-1:0] sz_min       = ghcc_pkg::DefMinSize;
  logic [ghcc_pkg::LenCfgW-1:0] sz_avg       = ghcc_pkg::DefAvgSize;
  logic [ghcc_pkg::LenCfgW-1:0] sz_max       = ghcc_pkg::DefMaxSize;
  logic [ghcc_pkg::MaskW-1:0]   msk_pre_avg  = ghcc_pkg::DefEarlyMask;
  logic [ghcc_pkg::MaskW-1:0]   msk_post_avg = ghcc_pkg::DefLateMask;

  ghcc_pkg::in_item_t  byte_feed_q[$];
  ghcc_pkg::out_item_t chunk_marks_q[$];

  int unsigned mismatches = 0;
  int unsigned cycle_cnt  = 0;
  logic in_done = 1'b0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit rx_hold_req = 1'b0;
  bit rx_hold_started = 1'b0;
  int tx_gap = 0;
  int rx_wait = 0;
  ghcc_pkg::out_item_t mark_want;

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ghcc_pkg::MaskW-1:0] rand_mask();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return ghcc_pkg::MaskW'($urandom);
      default: return (ghcc_pkg::MaskW'(1) << $urandom_range(0, 6)) - ghcc_pkg::MaskW'(1);
    endcase
  endfunction

  // One accepted transfer through the shadow chunker
  function automatic void advance_chunker(input ghcc_pkg::in_item_t it);
    logic [ghcc_pkg::MaskW-1:0] m;
    int unsigned lim;
    int unsigned len;
    bit cut;
    ghcc_pkg::out_item_t mark;
    if (ghcc_pkg::mode_e'(it.mode) == ghcc_pkg::ModeGearWrite) begin
      gear_shadow[it.gear_index] = it.gear_value;
      return;
    end
    cut = 1'b0;
    if (chunk_off >= sz_min) begin
      roll_hash = (roll_hash << 1) + gear_shadow[it.data_byte];
      m = (chunk_off < sz_avg) ? msk_pre_avg : msk_post_avg;
      if ((roll_hash[ghcc_pkg::MaskW-1:0] & m) == '0) cut = 1'b1;
    end
    len = chunk_off + 1;
    lim = (sz_max == '0) ? 1 : ((sz_max > MaxChunkLen) ? MaxChunkLen : sz_max);
    if (len >= lim || it.end_of_stream) cut = 1'b1;
    mark.chunk_end    = cut;
    mark.chunk_length = ghcc_pkg::LenCfgW'(len);
    chunk_marks_q.push_back(mark);
    if (cut) begin
      roll_hash = '0;
      chunk_off = 0;
    end else begin
      chunk_off = len;
    end
  endfunction

  function automatic void push_byte(input logic [ghcc_pkg::ByteW-1:0] b, input logic eos);
    ghcc_pkg::in_item_t it;
    it.mode          = ghcc_pkg::ModeData;
    it.data_byte     = b;
    it.end_of_stream = eos;
    it.gear_index    = ghcc_pkg::ByteW'($urandom);
    it.gear_value    = {$urandom, $urandom};
    byte_feed_q.push_back(it);
  endfunction

  function automatic void push_gear(input logic [ghcc_pkg::ByteW-1:0] idx,
                                    input logic [ghcc_pkg::GearW-1:0] val);
    ghcc_pkg::in_item_t it;
    it.mode          = ghcc_pkg::ModeGearWrite;
    it.data_byte     = ghcc_pkg::ByteW'($urandom);
    it.end_of_stream = 1'($urandom);
    it.gear_index    = idx;
    it.gear_value    = val;
    byte_feed_q.push_back(it);
  endfunction

  // Wait until every pending transfer has gone through and the pipe is empty
  task automatic drain();
    do @(negedge clk_i);
    while (byte_feed_q.size() != 0 || in_valid_i || chunk_marks_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [ghcc_pkg::CfgIdxW-1:0] idx,
                           input logic [ghcc_pkg::MaskW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      ghcc_pkg::CfgMinSize:   sz_min       = val[ghcc_pkg::LenCfgW-1:0];
      ghcc_pkg::CfgAvgSize:   sz_avg       = val[ghcc_pkg::LenCfgW-1:0];
      ghcc_pkg::CfgMaxSize:   sz_max       = val[ghcc_pkg::LenCfgW-1:0];
      ghcc_pkg::CfgEarlyMask: msk_pre_avg  = val;
      ghcc_pkg::CfgLateMask:  msk_post_avg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Size writes carry junk above bit 22, which the block must drop
  task automatic write_size(input ghcc_pkg::cfg_idx_e idx,
                            input logic [ghcc_pkg::LenCfgW-1:0] sz);
    logic [ghcc_pkg::MaskW-1:0] w;
    w = ghcc_pkg::MaskW'($urandom);
    w[ghcc_pkg::LenCfgW-1:0] = sz;
    write_reg(idx, w);
  endtask

  task automatic configure(input logic [ghcc_pkg::LenCfgW-1:0] mn,
                           input logic [ghcc_pkg::LenCfgW-1:0] av,
                           input logic [ghcc_pkg::LenCfgW-1:0] mx,
                           input logic [ghcc_pkg::MaskW-1:0] em,
                           input logic [ghcc_pkg::MaskW-1:0] lm);
    drain();
    write_size(ghcc_pkg::CfgMinSize, mn);
    write_size(ghcc_pkg::CfgAvgSize, av);
    write_size(ghcc_pkg::CfgMaxSize, mx);
    write_reg(ghcc_pkg::CfgEarlyMask, em);
    write_reg(ghcc_pkg::CfgLateMask, lm);
  endtask

  // Sender
  always @(negedge clk_i) begin
    if (!in_valid_i || in_done) begin
      if (tx_gap > 0) begin
        in_valid_i <= 1'b0;
        tx_gap--;
      end else if (byte_feed_q.size() > 0) begin
        in_item_i  <= byte_feed_q.pop_front();
        in_valid_i <= 1'b1;
        tx_gap = tx_idle ? idle_len() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    in_done <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) advance_chunker(in_item_i);
  end

  // Receiver: random back-pressure plus one long hold-off on request
  always @(negedge clk_i) begin
    if (rx_hold_req && !rx_hold_started) begin
      rx_hold_started = 1'b1;
      rx_wait = HoldCycles;
    end
    if (rx_wait > 0) begin
      out_ready_i <= 1'b0;
      rx_wait--;
    end else begin
      out_ready_i <= 1'b1;
      if (rx_idle && $urandom_range(0, 3) == 0) rx_wait = idle_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (chunk_marks_q.size() == 0) begin
        $display("%0t: unexpected transfer, chunk_end %0b chunk_length %0d", $time,
                 out_item_o.chunk_end, out_item_o.chunk_length);
        mismatches++;
      end else begin
        mark_want = chunk_marks_q.pop_front();
        if (out_item_o.chunk_end !== mark_want.chunk_end) begin
          $display("%0t: chunk_end expected %0b, got %0b", $time,
                   mark_want.chunk_end, out_item_o.chunk_end);
          mismatches++;
        end
        if (out_item_o.chunk_length !== mark_want.chunk_length) begin
          $display("%0t: chunk_length expected %0d, got %0d", $time,
                   mark_want.chunk_length, out_item_o.chunk_length);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [ghcc_pkg::LenCfgW-1:0] mn, av, mx;
    int n;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fill the whole gear table before any data byte is sent
    for (int i = 0; i < 256; i++) begin
      if (i == 0) push_gear(ghcc_pkg::ByteW'(i), '0);
      else if (i == 255) push_gear(ghcc_pkg::ByteW'(i), '1);
      else push_gear(ghcc_pkg::ByteW'(i), {$urandom, $urandom});
    end

    // Reset settings: nothing is hashed this early, only end of stream cuts
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h0F, 1'b1);

    drain();
    for (int i = int'(ghcc_pkg::CfgLateMask) + 1; i < (1 << ghcc_pkg::CfgIdxW); i++)
      write_reg(ghcc_pkg::CfgIdxW'(i), ghcc_pkg::MaskW'($urandom));

    // Maximum of zero: every byte is a chunk of its own
    configure('0, ghcc_pkg::LenCfgW'(4), '0, '1, '1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);

    // Late mask of zero cuts at the first byte past the average offset
    configure(ghcc_pkg::LenCfgW'(2), ghcc_pkg::LenCfgW'(4), ghcc_pkg::LenCfgW'(8), '1, '0);
    for (int i = 0; i < 6; i++) push_byte(ghcc_pkg::ByteW'($urandom), i == 5);

    // Minimum above maximum: only forced cuts
    configure(ghcc_pkg::LenCfgW'(10), ghcc_pkg::LenCfgW'(3), ghcc_pkg::LenCfgW'(6), '0, '0);
    for (int i = 0; i < 7; i++) push_byte(ghcc_pkg::ByteW'($urandom), i == 6);

    // Saturating maximum, table write in mid-chunk
    configure('0, ghcc_pkg::LenCfgW'(2), SizeAllOnes, '1, ghcc_pkg::MaskW'(1));
    push_byte(8'h01, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_gear(ghcc_pkg::ByteW'($urandom), {$urandom, $urandom});
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b1);

    for (int ph = 0; ph < RandPhases; ph++) begin
      case ($urandom_range(0, 5))
        0: mn = '0;
        1: mn = SizeAllOnes;
        default: mn = ghcc_pkg::LenCfgW'($urandom_range(0, 12));
      endcase
      case ($urandom_range(0, 5))
        0: av = '0;
        1: av = SizeAllOnes;
        default: av = ghcc_pkg::LenCfgW'($urandom_range(0, 30));
      endcase
      case ($urandom_range(0, 5))
        0: mx = '0;
        1: mx = SizeAllOnes;
        default: mx = ghcc_pkg::LenCfgW'($urandom_range(1, 48));
      endcase
      configure(mn, av, mx, rand_mask(), rand_mask());
      tx_idle = (ph != 2 && ph != 5);
      rx_idle = (ph != 2);
      // sender keeps offering while the receiver holds off, so the input stalls
      if (ph == 5) rx_hold_req = 1'b1;
      n = 0;
      while (n < PhaseBytes) begin
        if ($urandom_range(0, 24) == 0) begin
          push_gear(ghcc_pkg::ByteW'($urandom), {$urandom, $urandom});
        end else begin
          push_byte(ghcc_pkg::ByteW'($urandom), $urandom_range(0, 29) == 0);
          n++;
        end
      end
    end

    drain();
    if (mismatches == 0 && chunk_marks_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ghcc_pkg.sv
hdl/ghcc_ram.sv
hdl/gear_hash_content_chunker.sv
hdl/ghcc_checker.sv
test/gear_hash_content_chunker_tb.sv
